// ----- rtl/ttx_pkg.sv -----
`timescale 1ns / 1ps
// ttx_pkg: shared types, constants and national subset tables for the
// teletext character to utf-8 converter; no dependencies
package ttx_pkg;

  localparam int unsigned SubsetCount   = 13;
  localparam int unsigned NationalSlots = 13;
  localparam int unsigned UndocSlots    = 8;

  localparam int unsigned SubsetWidth = 4;
  localparam int unsigned CharWidth   = 7;
  localparam int unsigned CpWidth     = 9;

  typedef logic [SubsetWidth-1:0] subset_t;
  typedef logic [CharWidth-1:0]   char_t;
  typedef logic [CpWidth-1:0]     cp_t;

  // character positions with special meaning
  localparam char_t CharSpace      = 7'h20;
  localparam char_t CharQmark      = 7'h3f;
  localparam char_t CharDel        = 7'h7f;
  localparam char_t CharLineFeed   = 7'h0a;
  localparam char_t CharVertTab    = 7'h0b;
  localparam char_t CharCarReturn  = 7'h0d;
  // undocumented range 0x08-0x0f shares these upper bits
  localparam logic [3:0] UndocUpper = 4'h1;

  // utf-8 framing
  localparam cp_t        Utf8TwoByteMin = 9'h080;
  localparam logic [1:0] Utf8Len1       = 2'd1;
  localparam logic [1:0] Utf8Len2       = 2'd2;
  localparam logic [2:0] Utf8Lead2      = 3'b110;
  localparam logic [1:0] Utf8Cont       = 2'b10;

  // positions replaced by the national subset, in table slot order
  localparam char_t NationalPos [NationalSlots] = '{
    7'h23, 7'h24, 7'h40, 7'h5b, 7'h5c, 7'h5d, 7'h5e, 7'h5f,
    7'h60, 7'h7b, 7'h7c, 7'h7d, 7'h7e
  };

  localparam cp_t NationalTable [SubsetCount][NationalSlots] = '{
    '{9'h0a3, 9'h024, 9'h040, 9'h0ab, 9'h0bd, 9'h0bb, 9'h05e, 9'h023,
      9'h02d, 9'h0bc, 9'h0a6, 9'h0be, 9'h0f7},
    '{9'h023, 9'h024, 9'h0a7, 9'h0c4, 9'h0d6, 9'h0dc, 9'h05e, 9'h05f,
      9'h0b0, 9'h0e4, 9'h0f6, 9'h0fc, 9'h0df},
    '{9'h023, 9'h0a4, 9'h0c9, 9'h0c4, 9'h0d6, 9'h0c5, 9'h0dc, 9'h05f,
      9'h0e9, 9'h0e4, 9'h0f6, 9'h0e5, 9'h0fc},
    '{9'h0a3, 9'h024, 9'h0e9, 9'h0b0, 9'h0e7, 9'h0bb, 9'h05e, 9'h023,
      9'h0f9, 9'h0e0, 9'h0f2, 9'h0e8, 9'h0ec},
    '{9'h0e9, 9'h0ef, 9'h0e0, 9'h0eb, 9'h0ea, 9'h0f9, 9'h0ee, 9'h023,
      9'h0e8, 9'h0e2, 9'h0f4, 9'h0fb, 9'h0e7},
    '{9'h0e7, 9'h024, 9'h0a1, 9'h0e1, 9'h0e9, 9'h0ed, 9'h0f3, 9'h0fa,
      9'h0bf, 9'h0fc, 9'h0f1, 9'h0e8, 9'h0e0},
    '{9'h023, 9'h16f, 9'h10d, 9'h165, 9'h17e, 9'h0fd, 9'h0ed, 9'h159,
      9'h0e9, 9'h0e1, 9'h11b, 9'h0fa, 9'h161},
    '{9'h023, 9'h0a4, 9'h162, 9'h0c2, 9'h15e, 9'h102, 9'h0ce, 9'h131,
      9'h163, 9'h0e2, 9'h15f, 9'h103, 9'h0ee},
    '{9'h023, 9'h024, 9'h160, 9'h117, 9'h119, 9'h17d, 9'h10d, 9'h16b,
      9'h161, 9'h105, 9'h173, 9'h17e, 9'h12f},
    '{9'h023, 9'h144, 9'h105, 9'h05a, 9'h15a, 9'h141, 9'h107, 9'h0f3,
      9'h119, 9'h17c, 9'h15b, 9'h142, 9'h17a},
    '{9'h023, 9'h0cb, 9'h10c, 9'h106, 9'h17d, 9'h110, 9'h160, 9'h0eb,
      9'h10d, 9'h107, 9'h17e, 9'h111, 9'h161},
    '{9'h023, 9'h0f5, 9'h160, 9'h0c4, 9'h0d6, 9'h17e, 9'h0dc, 9'h0d5,
      9'h161, 9'h0e4, 9'h0f6, 9'h17e, 9'h0fc},
    '{9'h054, 9'h11f, 9'h130, 9'h15e, 9'h0d6, 9'h0c7, 9'h0dc, 9'h11e,
      9'h131, 9'h15f, 9'h0f6, 9'h0e7, 9'h0fc}
  };

  // undocumented positions 0x08-0x0f, indexed by the low three bits;
  // zero entries later turn into a question mark
  localparam cp_t UndocTable [SubsetCount][UndocSlots] = '{
    '{9'h000, 9'h000, 9'h000, 9'h000, 9'h000, 9'h000, 9'h000, 9'h000},
    '{9'h000, 9'h000, 9'h000, 9'h000, 9'h000, 9'h000, 9'h000, 9'h000},
    '{9'h000, 9'h000, 9'h000, 9'h000, 9'h000, 9'h000, 9'h000, 9'h000},
    '{9'h000, 9'h000, 9'h000, 9'h000, 9'h000, 9'h000, 9'h000, 9'h000},
    '{9'h000, 9'h0eb, 9'h000, 9'h0ef, 9'h000, 9'h000, 9'h000, 9'h000},
    '{9'h000, 9'h000, 9'h000, 9'h000, 9'h000, 9'h000, 9'h000, 9'h000},
    '{9'h000, 9'h000, 9'h000, 9'h000, 9'h000, 9'h000, 9'h000, 9'h000},
    '{9'h000, 9'h000, 9'h000, 9'h000, 9'h000, 9'h000, 9'h000, 9'h000},
    '{9'h000, 9'h000, 9'h000, 9'h000, 9'h000, 9'h000, 9'h000, 9'h000},
    '{9'h000, 9'h000, 9'h000, 9'h000, 9'h000, 9'h000, 9'h000, 9'h000},
    '{9'h000, 9'h000, 9'h000, 9'h000, 9'h000, 9'h000, 9'h000, 9'h000},
    '{9'h000, 9'h000, 9'h000, 9'h000, 9'h000, 9'h000, 9'h000, 9'h000},
    '{9'h000, 9'h000, 9'h000, 9'h000, 9'h000, 9'h000, 9'h000, 9'h000}
  };

  typedef struct packed {
    cp_t        code_point;
    logic [1:0] utf8_length;
    logic [7:0] first_byte;
    logic [7:0] second_byte;
  } result_t;

endpackage

// ----- rtl/ttx_if.sv -----
`timescale 1ns / 1ps
// ttx_char_if and ttx_utf8_if: valid/ready channels for teletext bytes in
// and code point plus utf-8 bytes out; no dependencies
interface ttx_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_byte;

  modport source (output valid, output char_byte, input ready);
  modport sink (input valid, input char_byte, output ready);
endinterface

interface ttx_utf8_if;
  logic       valid;
  logic       ready;
  logic [8:0] code_point;
  logic [1:0] utf8_length;
  logic [7:0] first_byte;
  logic [7:0] second_byte;

  modport source (
    output valid, output code_point, output utf8_length,
    output first_byte, output second_byte, input ready
  );
  modport sink (
    input valid, input code_point, input utf8_length,
    input first_byte, input second_byte, output ready
  );
endinterface

// ----- rtl/teletext_char_to_utf8.sv -----
`timescale 1ns / 1ps
// teletext_char_to_utf8: top level, teletext byte in, code point and utf-8 out
// depends on ttx_pkg, ttx_if, ttx_lookup and ttx_utf8_enc
//
//   channel   | dir | handshake          | payload
//   ----------+-----+--------------------+----------------------------------------
//   char_i    | in  | valid/ready        | char_byte[7:0] (bit 7 ignored)
//   utf8_o    | out | valid/ready        | code_point, utf8_length, first/second byte
//   cfg       | in  | cfg_we_i, no ready | cfg_wdata_i[3:0] national subset select
//
// one beat per cycle sustained while utf8_o is not stalled; a taken beat goes to
// the input register, then through lookup + encode into the result register
// reset clears both valid flags and selects the first national subset
// a stalled output holds its beat; the input register still takes a beat while
// it is empty or the result register is empty or draining in the same cycle
module teletext_char_to_utf8 (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [3:0]          cfg_wdata_i,
  ttx_char_if.sink            char_i,
  ttx_utf8_if.source          utf8_o
);

  // configuration register
  ttx_pkg::subset_t subset_q;

  // input stage
  logic           in_valid_q;
  ttx_pkg::char_t char_q;
  logic           in_ready;

  // result stage
  logic             out_valid_q;
  ttx_pkg::result_t res_q;
  ttx_pkg::result_t res_d;
  logic             out_ready;

  ttx_pkg::cp_t cp;

  // result register frees up when empty or taken this cycle
  assign out_ready = !out_valid_q || utf8_o.ready;
  // input register takes a new beat when empty or when its beat can advance
  assign in_ready  = !in_valid_q || out_ready;
  assign char_i.ready = in_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      subset_q <= '0;
    end else if (cfg_we_i) begin
      subset_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready) begin
        in_valid_q <= char_i.valid;
      end
      if (out_ready) begin
        out_valid_q <= in_valid_q;
      end
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk_i) begin
    if (char_i.valid && in_ready) begin
      char_q <= char_i.char_byte[6:0];
    end
    if (in_valid_q && out_ready) begin
      res_q <= res_d;
    end
  end

  // national substitution and printable filtering
  ttx_lookup u_lookup (
    .char_i       (char_q),
    .subset_i     (subset_q),
    .code_point_o (cp)
  );

  // utf-8 framing of the code point
  ttx_utf8_enc u_enc (
    .code_point_i (cp),
    .result_o     (res_d)
  );

  assign utf8_o.valid       = out_valid_q;
  assign utf8_o.code_point  = res_q.code_point;
  assign utf8_o.utf8_length = res_q.utf8_length;
  assign utf8_o.first_byte  = res_q.first_byte;
  assign utf8_o.second_byte = res_q.second_byte;

`ifndef SYNTH
  // a taken input beat always lands in the input register
  a_in_capture: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (char_i.valid && char_i.ready) |=> in_valid_q)
    else $error("accepted beat not held in input register");

  // a beat in the input register moves to the result when it has room
  a_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && out_ready) |=> out_valid_q)
    else $error("input register beat lost on advance");

  // the two utf-8 framings are consistent with the length
  a_framing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    utf8_o.valid |->
      ((utf8_o.utf8_length == ttx_pkg::Utf8Len1) && (utf8_o.second_byte == '0)
        && !utf8_o.first_byte[7])
      || ((utf8_o.utf8_length == ttx_pkg::Utf8Len2)
        && (utf8_o.first_byte[7:5] == ttx_pkg::Utf8Lead2)
        && (utf8_o.second_byte[7:6] == ttx_pkg::Utf8Cont)))
    else $error("utf-8 bytes do not match length");

  // a zero code point never leaves the block
  a_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    utf8_o.valid |-> (utf8_o.code_point != '0))
    else $error("zero code point delivered");
`endif

endmodule

// ----- rtl/ttx_lookup.sv -----
`timescale 1ns / 1ps
// ttx_lookup: maps a 7-bit teletext character to a unicode code point
// using the selected national subset; depends on ttx_pkg
module ttx_lookup (
  input  ttx_pkg::char_t   char_i,
  input  ttx_pkg::subset_t subset_i,
  output ttx_pkg::cp_t     code_point_o
);

  ttx_pkg::subset_t sel;
  logic             nat_hit;
  logic [3:0]       nat_slot;
  logic             undoc_hit;
  ttx_pkg::cp_t     cp;

  always_comb begin
    // out-of-range selector falls back to the first table
    sel = (subset_i >= ttx_pkg::SubsetWidth'(ttx_pkg::SubsetCount)) ? '0 : subset_i;

    nat_hit  = 1'b0;
    nat_slot = '0;
    for (int i = 0; i < ttx_pkg::NationalSlots; i++) begin
      if (char_i == ttx_pkg::NationalPos[i]) begin
        nat_hit  = 1'b1;
        nat_slot = 4'(i);
      end
    end

    undoc_hit = (char_i[6:3] == ttx_pkg::UndocUpper)
             && (char_i != ttx_pkg::CharLineFeed)
             && (char_i != ttx_pkg::CharVertTab)
             && (char_i != ttx_pkg::CharCarReturn);

    if (nat_hit) begin
      cp = ttx_pkg::NationalTable[sel][nat_slot];
    end else if (undoc_hit) begin
      cp = ttx_pkg::UndocTable[sel][char_i[2:0]];
    end else if ((char_i > ttx_pkg::CharSpace) && (char_i < ttx_pkg::CharDel)) begin
      cp = {2'b00, char_i};
    end else begin
      cp = {2'b00, ttx_pkg::CharSpace};
    end

    // missing table entry shows as a question mark
    if (cp == '0) begin
      cp = {2'b00, ttx_pkg::CharQmark};
    end
  end

  assign code_point_o = cp;

endmodule

// ----- rtl/ttx_utf8_enc.sv -----
`timescale 1ns / 1ps
// ttx_utf8_enc: one- or two-byte utf-8 encoding of a 9-bit code point;
// depends on ttx_pkg
module ttx_utf8_enc (
  input  ttx_pkg::cp_t    code_point_i,
  output ttx_pkg::result_t result_o
);

  always_comb begin
    result_o.code_point = code_point_i;
    if (code_point_i >= ttx_pkg::Utf8TwoByteMin) begin
      result_o.utf8_length = ttx_pkg::Utf8Len2;
      result_o.first_byte  = {ttx_pkg::Utf8Lead2, 2'b00, code_point_i[8:6]};
      result_o.second_byte = {ttx_pkg::Utf8Cont, code_point_i[5:0]};
    end else begin
      result_o.utf8_length = ttx_pkg::Utf8Len1;
      result_o.first_byte  = {1'b0, code_point_i[6:0]};
      result_o.second_byte = '0;
    end
  end

endmodule
